/* rtl/core/mdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types and codes for the MESI direct-mapped cache controller.
// ----------------------------------------------------------------------------
package mdc_pkg;

   localparam logic [1:0] KIND_RD    = 2'd0;
   localparam logic [1:0] KIND_WR    = 2'd1;
   localparam logic [1:0] KIND_SNOOP = 2'd2;
   localparam logic [1:0] KIND_RESP  = 2'd3;

   localparam logic [1:0] BUS_NONE   = 2'd0;
   localparam logic [1:0] BUS_RD     = 2'd1;
   localparam logic [1:0] BUS_RDX    = 2'd2;
   localparam logic [1:0] BUS_WRBACK = 2'd3;

   localparam logic [1:0] REQ_RD    = 2'd0;
   localparam logic [1:0] REQ_RDX   = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;

   typedef enum logic [1:0] {
      MESI_I = 2'd0,
      MESI_S = 2'd1,
      MESI_E = 2'd2,
      MESI_M = 2'd3
   } mesi_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_STREAM
   } fsm_type;

endpackage

/* rtl/core/mesi_direct_mapped_cache_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesi_direct_mapped_cache_ctrl
// Direct-mapped write-back cache with MESI snooping, tag and data in RAMs.
// ----------------------------------------------------------------------------
// Usage: drive req_* and pulse start while busy is low; the item is taken at
// that edge. Results appear on rsp_* for one cycle each, flagged by
// rsp_strobe; rsp_last marks the final result of an item. The receiver
// cannot stall.
// Operation: the tag and data RAMs are read at the accepting edge, so the
// one result of most items shows in the cycle right after start; busy is
// high for that one cycle, so no new item is taken until that result has
// shown. A snooped BusRd/BusRdX hitting a Modified line streams BLOCK_WORDS
// words from the data RAM, one per cycle, the first in ST_STREAM, which
// follows ST_LOOKUP; busy stays high until the last word, so no new item
// is taken while the block streams.
// Reset: a clearing pass writes every tag RAM entry to Invalid, one per
// cycle, with busy high. Configuration writes on csr_* are accepted at any
// time (csr_ready is always high).
// ----------------------------------------------------------------------------
module mesi_direct_mapped_cache_ctrl #(
   parameter int NUM_LINES   = 64,
   parameter int BLOCK_WORDS = 8,
   parameter int TAG_BITS    = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [20:0] req_addr,
   input  logic [31:0] req_data_in,
   input  logic [1:0]  req_bus_cmd,
   input  logic        req_request_pending,
   input  logic        req_bus_owned_by_me,
   input  logic [1:0]  req_own_pending_cmd,
   input  logic        req_shared_at_request,
   output logic        rsp_strobe,
   output logic        rsp_hit,
   output logic [31:0] rsp_read_data,
   output logic        rsp_request_valid,
   output logic [1:0]  rsp_request_cmd,
   output logic [20:0] rsp_request_addr,
   output logic        rsp_snoop_shared,
   output logic        rsp_provide_data,
   output logic [31:0] rsp_flush_word,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);
   import mdc_pkg::*;

   localparam int OFF_W = $clog2(BLOCK_WORDS);
   localparam int IDX_W = $clog2(NUM_LINES);
   localparam int TE_W  = TAG_BITS + 2;
   localparam int DA_W  = IDX_W + OFF_W;

   // tag RAM entry: {tag, mesi}
   logic [TE_W-1:0] tag_mem [NUM_LINES];
   logic [31:0]     data_mem [NUM_LINES*BLOCK_WORDS];

   fsm_type st_ff, st_in;
   logic [IDX_W:0]   clr_ff, clr_in;
   logic [OFF_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       core_id_ff;

   logic [1:0]  kind_ff;
   logic [20:0] addr_ff;
   logic [31:0] din_ff;
   logic [1:0]  cmd_ff, own_ff;
   logic        pend_ff, owned_ff, shreq_ff;

   logic [TE_W-1:0] trd_ff;
   logic [31:0]     drd_ff;

   logic            t_we, d_we;
   logic [IDX_W-1:0] t_wa;
   logic [TE_W-1:0] t_wd;
   logic [DA_W-1:0] d_wa, d_ra;
   logic [31:0]     d_wd;
   logic            d_re;

   logic [OFF_W-1:0]    off;
   logic [IDX_W-1:0]    idx;
   logic [TAG_BITS-1:0] tag, ltag;
   mesi_type            lst;
   logic                match;

   assign off   = addr_ff[OFF_W-1:0];
   assign idx   = addr_ff[OFF_W +: IDX_W];
   assign tag   = addr_ff[OFF_W+IDX_W +: TAG_BITS];
   assign ltag  = trd_ff[TE_W-1:2];
   assign lst   = mesi_type'(trd_ff[1:0]);
   assign match = (lst != MESI_I) && (ltag == tag);
   assign csr_ready = 1'b1;

   // tag RAM read address follows the incoming item at acceptance
   always_ff @(posedge clock) begin
      if (t_we) tag_mem[t_wa] <= t_wd;
      if (st_ff == ST_IDLE) trd_ff <= tag_mem[req_addr[OFF_W +: IDX_W]];
   end

   always_ff @(posedge clock) begin
      if (d_we) data_mem[d_wa] <= d_wd;
      if (d_re) drd_ff <= data_mem[d_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         clr_ff     <= '0;
         cnt_ff     <= '0;
         core_id_ff <= 2'd0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
         if (csr_valid && csr_ready) core_id_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff  <= req_kind;
         addr_ff  <= req_addr;
         din_ff   <= req_data_in;
         cmd_ff   <= req_bus_cmd;
         pend_ff  <= req_request_pending;
         owned_ff <= req_bus_owned_by_me;
         own_ff   <= req_own_pending_cmd;
         shreq_ff <= req_shared_at_request;
      end
   end

   logic clearing;
   assign clearing = (clr_ff != NUM_LINES[IDX_W:0]);

   always_comb begin
      logic [TAG_BITS+IDX_W+OFF_W-1:0] vaddr;
      st_in  = st_ff;
      clr_in = clr_ff;
      cnt_in = cnt_ff;
      busy   = clearing || (st_ff != ST_IDLE);
      t_we = 1'b0; t_wa = idx; t_wd = trd_ff;
      d_we = 1'b0; d_wa = {idx, off}; d_wd = din_ff;
      d_re = 1'b0; d_ra = {idx, off};
      vaddr = {ltag, idx, {OFF_W{1'b0}}};
      rsp_strobe = 1'b0; rsp_hit = 1'b0; rsp_read_data = '0;
      rsp_request_valid = 1'b0; rsp_request_cmd = REQ_RD; rsp_request_addr = '0;
      rsp_snoop_shared = 1'b0; rsp_provide_data = 1'b0; rsp_flush_word = '0;
      rsp_last = 1'b0;
      if (clearing) begin
         t_we   = 1'b1;
         t_wa   = clr_ff[IDX_W-1:0];
         t_wd   = {{TAG_BITS{1'b0}}, MESI_I};
         clr_in = clr_ff + 1'b1;
      end else begin
         unique case (st_ff)
            ST_IDLE: begin
               if (start) st_in = ST_LOOKUP;
            end
            ST_LOOKUP: begin
               // tag and data words are both ready this cycle
               rsp_strobe = 1'b1;
               rsp_last   = 1'b1;
               st_in      = ST_IDLE;
               unique case (kind_ff)
                  KIND_RD, KIND_WR: begin
                     if (kind_ff == KIND_RD ? match
                         : (match && (lst == MESI_M || lst == MESI_E))) begin
                        rsp_hit = 1'b1;
                        if (kind_ff == KIND_RD) rsp_read_data = drd_ff;
                        else begin
                           d_we = 1'b1;
                           t_we = 1'b1;
                           t_wd = {ltag, MESI_M};
                        end
                     end else if (!pend_ff && !owned_ff) begin
                        rsp_request_valid = 1'b1;
                        if (lst == MESI_M) begin
                           rsp_request_cmd  = REQ_FLUSH;
                           rsp_request_addr = 21'(vaddr);
                           t_we = 1'b1;
                           t_wd = {ltag, MESI_I};
                        end else begin
                           rsp_request_cmd  = (kind_ff == KIND_RD) ? REQ_RD : REQ_RDX;
                           rsp_request_addr = addr_ff;
                        end
                     end
                  end
                  KIND_SNOOP: begin
                     if (match && (cmd_ff == BUS_RD || cmd_ff == BUS_RDX)) begin
                        t_we = 1'b1;
                        t_wd = {ltag, (cmd_ff == BUS_RD) ? MESI_S : MESI_I};
                        if (lst == MESI_M) begin
                           rsp_strobe = 1'b0;
                           rsp_last   = 1'b0;
                           d_re       = 1'b1;
                           d_ra       = {idx, {OFF_W{1'b0}}};
                           cnt_in     = '0;
                           st_in      = ST_STREAM;
                        end else begin
                           rsp_snoop_shared = (cmd_ff == BUS_RD);
                        end
                     end
                  end
                  default: begin
                     if (cmd_ff == BUS_WRBACK && owned_ff && own_ff != REQ_FLUSH) begin
                        d_we = 1'b1;
                        if (off == OFF_W'(BLOCK_WORDS-1)) begin
                           t_we = 1'b1;
                           t_wd = {tag, (own_ff == REQ_RD)
                                   ? (shreq_ff ? MESI_S : MESI_E) : MESI_M};
                        end
                     end
                  end
               endcase
            end
            ST_STREAM: begin
               rsp_strobe       = 1'b1;
               rsp_snoop_shared = (cmd_ff == BUS_RD);
               rsp_provide_data = 1'b1;
               rsp_flush_word   = drd_ff;
               d_re   = 1'b1;
               d_ra   = {idx, OFF_W'(cnt_ff + 1'b1)};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == OFF_W'(BLOCK_WORDS-1)) begin
                  rsp_last = 1'b1;
                  st_in    = ST_IDLE;
               end
            end
            default: st_in = ST_IDLE;
         endcase
      end
      // data read for a lookup happens in the idle cycle at acceptance
      if (st_ff == ST_IDLE && !clearing) begin
         d_re = 1'b1;
         d_ra = {req_addr[OFF_W +: IDX_W], req_addr[OFF_W-1:0]};
      end
   end

   logic unused_cid;
   assign unused_cid = ^core_id_ff;

endmodule

/* test/mesi_direct_mapped_cache_ctrl_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesi_direct_mapped_cache_ctrl_test
// Self-checking bench for the MESI direct-mapped cache controller. A local
// copy of the tag, state and data arrays predicts every result beat; items
// are sent in bursts with random gaps, directed cases first, then random
// line fills, core accesses and snoops over a small set of lines, and noise.
// ----------------------------------------------------------------------------
module mesi_direct_mapped_cache_ctrl_test;
   import mdc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int NUM_RANDOM = 400;

   typedef struct packed {
      logic [1:0]  kind;
      logic [20:0] addr;
      logic [31:0] data;
      logic [1:0]  cmd;
      logic        pend;
      logic        owned;
      logic [1:0]  owncmd;
      logic        shreq;
   } cache_req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_data;
      logic        req_valid;
      logic [1:0]  req_cmd;
      logic [20:0] req_addr;
      logic        shared;
      logic        provide;
      logic [31:0] flush_word;
      logic        last;
   } cache_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = '0;
   logic [20:0] req_addr = '0;
   logic [31:0] req_data_in = '0;
   logic [1:0]  req_bus_cmd = '0;
   logic        req_request_pending = 1'b0;
   logic        req_bus_owned_by_me = 1'b0;
   logic [1:0]  req_own_pending_cmd = '0;
   logic        req_shared_at_request = 1'b0;
   logic        rsp_strobe, rsp_hit, rsp_request_valid, rsp_snoop_shared;
   logic        rsp_provide_data, rsp_last;
   logic [31:0] rsp_read_data, rsp_flush_word;
   logic [1:0]  rsp_request_cmd;
   logic [20:0] rsp_request_addr;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data = '0;

   mesi_direct_mapped_cache_ctrl u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_addr(req_addr), .req_data_in(req_data_in),
      .req_bus_cmd(req_bus_cmd), .req_request_pending(req_request_pending),
      .req_bus_owned_by_me(req_bus_owned_by_me),
      .req_own_pending_cmd(req_own_pending_cmd),
      .req_shared_at_request(req_shared_at_request),
      .rsp_strobe(rsp_strobe), .rsp_hit(rsp_hit), .rsp_read_data(rsp_read_data),
      .rsp_request_valid(rsp_request_valid), .rsp_request_cmd(rsp_request_cmd),
      .rsp_request_addr(rsp_request_addr), .rsp_snoop_shared(rsp_snoop_shared),
      .rsp_provide_data(rsp_provide_data), .rsp_flush_word(rsp_flush_word),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // shadow cache
   mesi_type    line_state [64];
   logic [11:0] line_tag [64];
   logic [31:0] word_store [512];
   bit          word_valid [512];
   logic [1:0]  core_id;

   cache_rsp_type pending_rsp_q [$];
   int          errors = 0;
   int          cycles = 0;
   int          burst_left = 0;
   logic [5:0]  idx_pool [4];
   logic [11:0] tag_pool [3];

   function automatic cache_req_type mk(logic [1:0] kind, logic [20:0] addr,
                                        logic [31:0] data, logic [1:0] cmd,
                                        logic pend, logic owned,
                                        logic [1:0] owncmd, logic shreq);
      cache_req_type r;
      r = '{kind, addr, data, cmd, pend, owned, owncmd, shreq};
      return r;
   endfunction

   // keep away from reads of words never written
   function automatic cache_req_type legalize(cache_req_type r);
      logic [5:0] idx;
      bit         full;
      idx = r.addr[8:3];
      if (line_state[idx] != MESI_I && line_tag[idx] == r.addr[20:9]) begin
         if (r.kind == KIND_RD && !word_valid[{idx, r.addr[2:0]}])
            r.kind = KIND_WR;
         if (r.kind == KIND_SNOOP && line_state[idx] == MESI_M &&
             (r.cmd == BUS_RD || r.cmd == BUS_RDX)) begin
            full = 1;
            for (int i = 0; i < 8; i++) full &= word_valid[{idx, i[2:0]}];
            if (!full) r.cmd = BUS_NONE;
         end
      end
      return r;
   endfunction

   function automatic void predict_cache(cache_req_type r);
      cache_rsp_type e;
      logic [5:0] idx;
      logic [8:0] wa;
      bit         match, hit;
      idx = r.addr[8:3];
      wa = {idx, r.addr[2:0]};
      match = line_state[idx] != MESI_I && line_tag[idx] == r.addr[20:9];
      e = '0;
      e.last = 1'b1;
      case (r.kind)
         KIND_RD, KIND_WR: begin
            hit = (r.kind == KIND_RD) ? match :
                  match && (line_state[idx] == MESI_M || line_state[idx] == MESI_E);
            if (hit) begin
               e.hit = 1'b1;
               if (r.kind == KIND_RD) begin
                  e.read_data = word_store[wa];
               end else begin
                  word_store[wa] = r.data;
                  word_valid[wa] = 1;
                  line_state[idx] = MESI_M;
               end
            end else if (!r.pend && !r.owned) begin
               e.req_valid = 1'b1;
               if (line_state[idx] == MESI_M) begin
                  // write back the victim first
                  e.req_cmd = REQ_FLUSH;
                  e.req_addr = {line_tag[idx], idx, 3'b000};
                  line_state[idx] = MESI_I;
               end else begin
                  e.req_cmd = (r.kind == KIND_RD) ? REQ_RD : REQ_RDX;
                  e.req_addr = r.addr;
               end
            end
            pending_rsp_q.push_back(e);
         end
         KIND_SNOOP: begin
            if (match && (r.cmd == BUS_RD || r.cmd == BUS_RDX)) begin
               e.shared = (r.cmd == BUS_RD);
               if (line_state[idx] == MESI_M) begin
                  e.provide = 1'b1;
                  for (int i = 0; i < 8; i++) begin
                     e.flush_word = word_store[{idx, i[2:0]}];
                     e.last = (i == 7);
                     pending_rsp_q.push_back(e);
                  end
               end else begin
                  pending_rsp_q.push_back(e);
               end
               line_state[idx] = (r.cmd == BUS_RD) ? MESI_S : MESI_I;
            end else begin
               pending_rsp_q.push_back(e);
            end
         end
         default: begin
            if (r.cmd == BUS_WRBACK && r.owned && r.owncmd != REQ_FLUSH) begin
               word_store[wa] = r.data;
               word_valid[wa] = 1;
               if (r.addr[2:0] == 3'd7) begin
                  line_tag[idx] = r.addr[20:9];
                  if (r.owncmd == REQ_RD) line_state[idx] = r.shreq ? MESI_S : MESI_E;
                  else line_state[idx] = MESI_M;
               end
            end
            pending_rsp_q.push_back(e);
         end
      endcase
   endfunction

   // one beat into the block; caller stands at a rising edge
   task automatic send_item(cache_req_type it);
      cache_req_type r;
      r = legalize(it);
      start <= 1'b1;
      req_kind <= r.kind;
      req_addr <= r.addr;
      req_data_in <= r.data;
      req_bus_cmd <= r.cmd;
      req_request_pending <= r.pend;
      req_bus_owned_by_me <= r.owned;
      req_own_pending_cmd <= r.owncmd;
      req_shared_at_request <= r.shreq;
      do @(posedge clock); while (busy);
      predict_cache(r);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_core_id(logic [1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      core_id = v;
   endtask

   // eight response words, in order, for one block
   task automatic fill_line(logic [5:0] idx, logic [11:0] tg, logic [1:0] owncmd,
                            logic shreq);
      for (int i = 0; i < 8; i++)
         send_item(mk(KIND_RESP, {tg, idx, i[2:0]}, $urandom, BUS_WRBACK, 1'b0,
                      1'b1, owncmd, shreq));
   endtask

   task automatic test_core_access();
      logic [20:0] a;
      a = {12'h123, 6'd5, 3'd0};
      write_core_id(2'd0);
      send_item(mk(KIND_RD, 21'h0, 32'hFFFF_FFFF, BUS_NONE, 0, 0, REQ_RD, 0));
      fill_line(6'd5, 12'h123, REQ_RD, 1'b0);
      send_item(mk(KIND_RD, a | 21'd3, 0, BUS_NONE, 0, 0, REQ_RD, 0));
      send_item(mk(KIND_WR, a | 21'd7, 32'hFFFF_FFFF, BUS_NONE, 0, 0, REQ_RD, 0));
      send_item(mk(KIND_SNOOP, a, 0, BUS_RD, 0, 0, REQ_RD, 0));
      send_item(mk(KIND_WR, a, 32'h0, BUS_NONE, 0, 0, REQ_RD, 0));
      send_item(mk(KIND_WR, {12'h777, 6'd5, 3'd1}, 1, BUS_NONE, 1, 1, REQ_RD, 0));
      send_item(mk(KIND_SNOOP, a, 0, BUS_RDX, 0, 0, REQ_RD, 0));
      wait_idle();
   endtask

   task automatic test_snoop_and_fill();
      logic [20:0] a;
      a = 21'h1F_FFFF;
      write_core_id(2'd3);
      send_item(mk(KIND_RESP, a, 32'hA5A5_A5A5, BUS_NONE, 0, 1, REQ_RD, 0));
      send_item(mk(KIND_RESP, a, 32'hA5A5_A5A5, BUS_WRBACK, 0, 0, REQ_RD, 0));
      send_item(mk(KIND_RESP, a, 32'hA5A5_A5A5, BUS_WRBACK, 0, 1, REQ_FLUSH, 0));
      send_item(mk(KIND_RD, a, 0, BUS_NONE, 1, 0, REQ_RD, 0));
      fill_line(6'd63, 12'hFFF, 2'd3, 1'b1);
      send_item(mk(KIND_SNOOP, a, 0, BUS_WRBACK, 0, 0, REQ_RD, 0));
      send_item(mk(KIND_SNOOP, a, 0, BUS_NONE, 0, 0, REQ_RD, 0));
      send_item(mk(KIND_WR, {12'h000, 6'd63, 3'd2}, 5, BUS_NONE, 0, 0, REQ_RD, 0));
      send_item(mk(KIND_RD, a, 0, BUS_NONE, 0, 0, REQ_RD, 0));
      wait_idle();
   endtask

   function automatic logic [20:0] pool_addr();
      return {tag_pool[$urandom_range(0, 2)], idx_pool[$urandom_range(0, 3)],
              3'($urandom_range(0, 7))};
   endfunction

   task automatic test_random_traffic(int n_items);
      int            sent;
      int            sel;
      logic [20:0]   a;
      cache_req_type r;
      sent = 0;
      for (int i = 0; i < 4; i++) idx_pool[i] = 6'($urandom);
      for (int i = 0; i < 3; i++) tag_pool[i] = 12'($urandom);
      while (sent < n_items) begin
         sel = $urandom_range(0, 99);
         a = pool_addr();
         if (sel < 22) begin
            fill_line(a[8:3], a[20:9], 2'($urandom_range(0, 1)), 1'($urandom));
            sent += 8;
         end else if (sel < 62) begin
            r = mk(1'($urandom), a, $urandom, 2'($urandom), 1'b0, 1'b0,
                   2'($urandom_range(0, 2)), 1'($urandom));
            if ($urandom_range(0, 4) == 0) begin
               r.pend = 1'($urandom);
               r.owned = 1'($urandom);
            end
            send_item(r);
            sent++;
         end else if (sel < 80) begin
            send_item(mk(KIND_SNOOP, a, $urandom, 2'($urandom), 1'($urandom),
                         1'($urandom), 2'($urandom), 1'($urandom)));
            sent++;
         end else begin
            // noise anywhere in the address space
            send_item(mk(2'($urandom), 21'($urandom), $urandom, 2'($urandom),
                         1'($urandom), 1'($urandom), 2'($urandom), 1'($urandom)));
            sent++;
         end
         if (sent % 100 < 8 && sent >= 100 && $urandom_range(0, 1) == 0) begin
            wait_idle();
            write_core_id(2'($urandom));
         end
      end
      wait_idle();
   endtask

   always @(posedge clock) begin
      cache_rsp_type e;
      if (!reset && rsp_strobe) begin
         if (pending_rsp_q.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            e = pending_rsp_q.pop_front();
            if (rsp_hit !== e.hit) begin
               $error("hit exp %h got %h", e.hit, rsp_hit); errors++;
            end
            if (rsp_read_data !== e.read_data) begin
               $error("read_data exp %h got %h", e.read_data, rsp_read_data); errors++;
            end
            if (rsp_request_valid !== e.req_valid) begin
               $error("request_valid exp %h got %h", e.req_valid, rsp_request_valid);
               errors++;
            end
            if (rsp_request_cmd !== e.req_cmd) begin
               $error("request_cmd exp %h got %h", e.req_cmd, rsp_request_cmd); errors++;
            end
            if (rsp_request_addr !== e.req_addr) begin
               $error("request_addr exp %h got %h", e.req_addr, rsp_request_addr);
               errors++;
            end
            if (rsp_snoop_shared !== e.shared) begin
               $error("snoop_shared exp %h got %h", e.shared, rsp_snoop_shared); errors++;
            end
            if (rsp_provide_data !== e.provide) begin
               $error("provide_data exp %h got %h", e.provide, rsp_provide_data); errors++;
            end
            if (rsp_flush_word !== e.flush_word) begin
               $error("flush_word exp %h got %h", e.flush_word, rsp_flush_word); errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %h got %h", e.last, rsp_last); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 64; i++) begin
         line_state[i] = MESI_I;
         line_tag[i] = '0;
      end
      for (int i = 0; i < 512; i++) begin
         word_store[i] = '0;
         word_valid[i] = 0;
      end
      core_id = 2'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // the receiver cannot stall; only the sender idles
      test_core_access();
      test_snoop_and_fill();
      test_random_traffic(NUM_RANDOM / 2);
      write_core_id(2'd1);
      test_random_traffic(NUM_RANDOM / 2);
      if (errors == 0 && pending_rsp_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/mdc_pkg.sv
rtl/core/mesi_direct_mapped_cache_ctrl.sv
test/mesi_direct_mapped_cache_ctrl_test.sv
